### hw/rtl/vfc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfc_pkg
// Shared constants and types of the view frustum culling block.
// ---------------------------------------------------------------------------
package vfc_pkg;

   localparam int NUM_PLANES  = 6;
   localparam int FRAC_BITS   = 16;
   localparam int BOX_CORNERS = 8;
   localparam int PLANE_W     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
   localparam int PROD_W      = 64;
   localparam int DIST_W      = 66;
   localparam int NUM_TERMS   = 6;

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_SPHERE = 2'd1;
   localparam logic [1:0] REQ_BOX    = 2'd2;
   localparam logic [1:0] REQ_LINE   = 2'd3;

   localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
   localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
   localparam logic [1:0] VERDICT_INSIDE    = 2'd2;

   typedef struct packed {
      logic                   sph_out;
      logic                   sph_hit;
      logic                   a_behind;
      logic                   b_behind;
      logic [BOX_CORNERS-1:0] corner_behind;
   } eval_flags_type;

endpackage

### hw/rtl/vfc_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vfc_eval
// Forms the plane distances of all box corners from the six registered
// products and the plane offset, and compares them for the current test.
// ---------------------------------------------------------------------------
module vfc_eval import vfc_pkg::*; (
   input  wire logic signed [PROD_W-1:0] term [NUM_TERMS],
   input  wire logic signed [31:0]       offset,
   input  wire logic signed [DIST_W-1:0] thresh,
   output eval_flags_type                flags
);

   logic signed [DIST_W-1:0] off_ext;
   logic signed [DIST_W-1:0] corner_dist [BOX_CORNERS];

   assign off_ext = DIST_W'(offset) <<< FRAC_BITS;

   // Corner bit 2 picks the second point's x, bit 1 its y, bit 0 its z; corner 0 is the first point.
   always_comb begin
      for (int j = 0; j < BOX_CORNERS; j++) begin
         corner_dist[j] = DIST_W'(j[2] ? term[3] : term[0])
                        + DIST_W'(j[1] ? term[4] : term[1])
                        + DIST_W'(j[0] ? term[5] : term[2])
                        + off_ext;
         flags.corner_behind[j] = corner_dist[j] < 0;
      end
      flags.a_behind = corner_dist[0] < 0;
      flags.b_behind = corner_dist[BOX_CORNERS-1] < 0;
      flags.sph_out  = corner_dist[0] < -thresh;
      flags.sph_hit  = (corner_dist[0] < thresh) && (corner_dist[0] > -thresh);
   end

endmodule
`default_nettype wire

### hw/rtl/view_frustum_culling.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// view_frustum_culling
// Classifies spheres, boxes and segments against six stored frustum planes.
// ---------------------------------------------------------------------------
// A load item writes one plane, if its slot is below NUM_PLANES, and goes
// straight to the finish state. A test item walks the stored planes in order
// through one shared 32x32 multiplier: six products per plane, then a compare
// in the evaluate state; a test ends early when a plane settles the verdict.
// The input is stalled while an item is at work.
module view_frustum_culling import vfc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_type,
   input  wire logic [2:0]         req_plane_slot,
   input  wire logic signed [31:0] req_first_x,
   input  wire logic signed [31:0] req_first_y,
   input  wire logic signed [31:0] req_first_z,
   input  wire logic signed [31:0] req_second_x,
   input  wire logic signed [31:0] req_second_y,
   input  wire logic signed [31:0] req_second_z,
   input  wire logic signed [31:0] req_scalar_value,
   input  wire logic signed [31:0] req_radius_bias,
   input  wire logic               req_early_accept,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_verdict,
   output logic                    rsp_load_done
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MUL    = 2'd1;
   localparam logic [1:0] ST_EVAL   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;
   logic [1:0] kind_ff, kind_in;
   logic early_ff, early_in;
   logic hit_ff, hit_in, a_in_ff, a_in_in, b_in_ff, b_in_in, front_ff, front_in;
   logic [1:0] verdict_ff, verdict_in;
   logic load_ff, load_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_verdict_ff, rsp_verdict_in;
   logic rsp_load_ff, rsp_load_in;

   logic signed [31:0] pa_ff [3];
   logic signed [31:0] pb_ff [3];
   logic signed [DIST_W-1:0] thresh_ff;
   logic signed [PROD_W-1:0] term_ff [NUM_TERMS];

   logic signed [31:0] nx_ff [NUM_PLANES];
   logic signed [31:0] ny_ff [NUM_PLANES];
   logic signed [31:0] nz_ff [NUM_PLANES];
   logic signed [31:0] w_ff  [NUM_PLANES];

   logic accept, load_write, last_plane, rsp_free;
   logic signed [31:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   eval_flags_type flags;
   logic na, nb;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = state_ff != ST_IDLE;
   assign load_write = accept && req_type == REQ_LOAD
                       && {1'b0, req_plane_slot} < 4'(NUM_PLANES);
   assign last_plane = plane_ff == PLANE_W'(NUM_PLANES - 1);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (step_ff)
         3'd0:    begin mul_a = nx_ff[plane_ff]; mul_b = pa_ff[0]; end
         3'd1:    begin mul_a = ny_ff[plane_ff]; mul_b = pa_ff[1]; end
         3'd2:    begin mul_a = nz_ff[plane_ff]; mul_b = pa_ff[2]; end
         3'd3:    begin mul_a = nx_ff[plane_ff]; mul_b = pb_ff[0]; end
         3'd4:    begin mul_a = ny_ff[plane_ff]; mul_b = pb_ff[1]; end
         default: begin mul_a = nz_ff[plane_ff]; mul_b = pb_ff[2]; end
      endcase
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   vfc_eval u_eval (
      .term   (term_ff),
      .offset (w_ff[plane_ff]),
      .thresh (thresh_ff),
      .flags  (flags)
   );

   assign na = a_in_ff && !flags.a_behind;
   assign nb = b_in_ff && !flags.b_behind;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      plane_in   = plane_ff;
      kind_in    = kind_ff;
      early_in   = early_ff;
      hit_in     = hit_ff;
      a_in_in    = a_in_ff;
      b_in_in    = b_in_ff;
      front_in   = front_ff;
      verdict_in = verdict_ff;
      load_in    = load_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in    = req_type;
               early_in   = req_early_accept;
               step_in    = 3'd0;
               plane_in   = '0;
               hit_in     = 1'b0;
               a_in_in    = 1'b1;
               b_in_in    = 1'b1;
               front_in   = 1'b1;
               verdict_in = VERDICT_OUTSIDE;
               load_in    = req_type == REQ_LOAD;
               state_in   = (req_type == REQ_LOAD) ? ST_FINISH : ST_MUL;
            end
         end
         ST_MUL: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(NUM_TERMS - 1)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            step_in  = 3'd0;
            plane_in = plane_ff + PLANE_W'(1);
            state_in = last_plane ? ST_FINISH : ST_MUL;
            case (kind_ff)
               REQ_SPHERE: begin
                  hit_in     = hit_ff || flags.sph_hit;
                  verdict_in = hit_in ? VERDICT_INTERSECT : VERDICT_INSIDE;
                  if (flags.sph_out) begin
                     verdict_in = VERDICT_OUTSIDE;
                     state_in   = ST_FINISH;
                  end
               end
               REQ_BOX: begin
                  front_in   = front_ff && (flags.corner_behind == '0);
                  verdict_in = front_in ? VERDICT_INSIDE : VERDICT_INTERSECT;
                  if (early_ff && !(&flags.corner_behind)) begin
                     verdict_in = VERDICT_INTERSECT;
                     state_in   = ST_FINISH;
                  end else if (&flags.corner_behind) begin
                     verdict_in = VERDICT_OUTSIDE;
                     state_in   = ST_FINISH;
                  end
               end
               default: begin
                  a_in_in    = na;
                  b_in_in    = nb;
                  verdict_in = (na && nb) ? VERDICT_INSIDE : VERDICT_INTERSECT;
                  if (!na && !nb) begin
                     verdict_in = VERDICT_OUTSIDE;
                     state_in   = ST_FINISH;
                  end
               end
            endcase
         end
         default: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_load_in    = rsp_load_ff;
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_valid_in   = 1'b1;
         rsp_verdict_in = verdict_ff;
         rsp_load_in    = load_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         plane_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_PLANES; k++) begin
            nx_ff[k] <= '0;
            ny_ff[k] <= '0;
            nz_ff[k] <= '0;
            w_ff[k]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         plane_ff     <= plane_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_write) begin
            nx_ff[PLANE_W'(req_plane_slot)] <= req_first_x;
            ny_ff[PLANE_W'(req_plane_slot)] <= req_first_y;
            nz_ff[PLANE_W'(req_plane_slot)] <= req_first_z;
            w_ff[PLANE_W'(req_plane_slot)]  <= req_scalar_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      early_ff       <= early_in;
      hit_ff         <= hit_in;
      a_in_ff        <= a_in_in;
      b_in_ff        <= b_in_in;
      front_ff       <= front_in;
      verdict_ff     <= verdict_in;
      load_ff        <= load_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_load_ff    <= rsp_load_in;
      if (accept) begin
         pa_ff[0]  <= req_first_x;
         pa_ff[1]  <= req_first_y;
         pa_ff[2]  <= req_first_z;
         pb_ff[0]  <= req_second_x;
         pb_ff[1]  <= req_second_y;
         pb_ff[2]  <= req_second_z;
         thresh_ff <= (DIST_W'(req_scalar_value) + DIST_W'(req_radius_bias)) <<< FRAC_BITS;
      end
      if (state_ff == ST_MUL) begin
         term_ff[step_ff] <= mul_p;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_verdict   = rsp_verdict_ff;
   assign rsp_load_done = rsp_load_ff;

`ifndef SYNTHESIS
   a_load_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_load_done |-> rsp_verdict == VERDICT_OUTSIDE)
      else $error("load item returned a nonzero verdict");
   a_load_finish: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == REQ_LOAD |=> state_ff == ST_FINISH)
      else $error("load item did not go straight to completion");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> step_ff < 3'(NUM_TERMS))
      else $error("product step out of range");
   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> plane_ff < PLANE_W'(NUM_PLANES))
      else $error("plane index out of range");
`endif

endmodule
`default_nettype wire

### test/view_frustum_culling_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// view_frustum_culling_tb
// Drives plane loads and sphere, box and segment tests into the culling block
// under random idling and stalls, and checks each verdict against a predictor.
// ---------------------------------------------------------------------------
module view_frustum_culling_tb;
   import vfc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 900;

   typedef struct {
      logic [1:0]         kind;
      logic [2:0]         slot;
      logic signed [31:0] ax, ay, az, bx, by, bz, scalar, bias;
      logic               early;
   } cull_item_t;

   typedef struct {
      logic [1:0] verdict;
      logic       load_done;
   } verdict_t;

   // Keeps its own copy of the planes and predicts one verdict per item.
   class cull_scoreboard;
      logic signed [31:0] nx[NUM_PLANES], ny[NUM_PLANES], nz[NUM_PLANES];
      logic signed [31:0] off[NUM_PLANES];
      verdict_t pending_verdicts[$];
      int mismatches, checked;

      function new();
         for (int k = 0; k < NUM_PLANES; k++) begin
            nx[k] = 0; ny[k] = 0; nz[k] = 0; off[k] = 0;
         end
         mismatches = 0;
         checked = 0;
      endfunction

      // The exact sum fits in 66 bits, so no wrap changes a sign or a compare
      // against a 49-bit threshold, and the exact value is used.
      function logic signed [65:0] distance(int k, logic signed [31:0] px,
                                             logic signed [31:0] py,
                                             logic signed [31:0] pz);
         logic signed [65:0] d;
         d = 66'(nx[k] * 64'(px)) + 66'(ny[k] * 64'(py)) + 66'(nz[k] * 64'(pz));
         d = d + (66'(off[k]) <<< FRAC_BITS);
         return d;
      endfunction

      function logic [1:0] classify(cull_item_t it);
         logic signed [65:0] d, t, ad;
         logic signed [31:0] cx, cy, cz;
         logic hit, a_in, b_in;
         int front, planes_in;
         case (it.kind)
            REQ_SPHERE: begin
               t = (66'(it.scalar) + 66'(it.bias)) <<< FRAC_BITS;
               hit = 0;
               for (int k = 0; k < NUM_PLANES; k++) begin
                  d = distance(k, it.ax, it.ay, it.az);
                  ad = (d < 0) ? -d : d;
                  if (d < -t) return VERDICT_OUTSIDE;
                  if (ad < t) hit = 1;
               end
               return hit ? VERDICT_INTERSECT : VERDICT_INSIDE;
            end
            REQ_BOX: begin
               planes_in = 0;
               for (int k = 0; k < NUM_PLANES; k++) begin
                  front = BOX_CORNERS;
                  for (int j = 0; j < BOX_CORNERS; j++) begin
                     cx = j[2] ? it.bx : it.ax;
                     cy = j[1] ? it.by : it.ay;
                     cz = j[0] ? it.bz : it.az;
                     if (distance(k, cx, cy, cz) < 0) front--;
                     else if (it.early) return VERDICT_INTERSECT;
                  end
                  if (front == 0) return VERDICT_OUTSIDE;
                  if (front == BOX_CORNERS) planes_in++;
               end
               return (planes_in == NUM_PLANES) ? VERDICT_INSIDE : VERDICT_INTERSECT;
            end
            default: begin
               a_in = 1; b_in = 1;
               for (int k = 0; k < NUM_PLANES; k++) begin
                  if (distance(k, it.ax, it.ay, it.az) < 0) a_in = 0;
                  if (distance(k, it.bx, it.by, it.bz) < 0) b_in = 0;
                  if (!a_in && !b_in) return VERDICT_OUTSIDE;
               end
               return (a_in && b_in) ? VERDICT_INSIDE : VERDICT_INTERSECT;
            end
         endcase
      endfunction

      function void note_item(cull_item_t it);
         verdict_t v;
         if (it.kind == REQ_LOAD) begin
            if (it.slot < NUM_PLANES) begin
               nx[it.slot] = it.ax; ny[it.slot] = it.ay; nz[it.slot] = it.az;
               off[it.slot] = it.scalar;
            end
            v.verdict = VERDICT_OUTSIDE;
            v.load_done = 1;
         end else begin
            v.verdict = classify(it);
            v.load_done = 0;
         end
         pending_verdicts.push_back(v);
      endfunction

      function void check_result(logic [1:0] verdict, logic load_done);
         verdict_t e;
         checked++;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: verdict %0d load_done %0d", verdict, load_done);
            return;
         end
         e = pending_verdicts.pop_front();
         if (e.verdict !== verdict || e.load_done !== load_done) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected verdict %0d load_done %0d, got %0d %0d",
                        e.verdict, e.load_done, verdict, load_done);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   logic [1:0] req_type = 0;
   logic [2:0] req_plane_slot = 0;
   logic signed [31:0] req_first_x = 0, req_first_y = 0, req_first_z = 0;
   logic signed [31:0] req_second_x = 0, req_second_y = 0, req_second_z = 0;
   logic signed [31:0] req_scalar_value = 0, req_radius_bias = 0;
   logic req_early_accept = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [1:0] rsp_verdict;
   logic rsp_load_done;

   cull_scoreboard verdicts = new();
   int idle_cycles = 0;
   int kind_count[4] = '{0, 0, 0, 0};
   bit hold_receiver = 0;
   bit receiver_held = 0;

   always #1 clock = ~clock;

   view_frustum_culling i_dut (.*);

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) idle_cycles <= 0;
      else if (!reset && rsp_valid && !rsp_stall) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) verdicts.check_result(rsp_verdict, rsp_load_done);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress");
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Receiver: random stalls, and one long hold-off on request.
   initial begin
      int g;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_receiver && !receiver_held) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            receiver_held = 1;
            rsp_stall <= 0;
         end else begin
            g = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
            if (g > 0) begin
               rsp_stall <= 1;
               repeat (g) @(posedge clock);
            end
            rsp_stall <= 0;
         end
      end
   end

   task automatic send_item(cull_item_t it, bit with_gap);
      int g;
      g = with_gap ? gap_length() : 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= it.kind;
      req_plane_slot <= it.slot;
      req_first_x <= it.ax; req_first_y <= it.ay; req_first_z <= it.az;
      req_second_x <= it.bx; req_second_y <= it.by; req_second_z <= it.bz;
      req_scalar_value <= it.scalar;
      req_radius_bias <= it.bias;
      req_early_accept <= it.early;
      do @(posedge clock); while (req_stall);
      verdicts.note_item(it);
      kind_count[it.kind]++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (verdicts.pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // Mostly modest coordinates so verdicts spread; now and then full range.
   function automatic logic signed [31:0] pick_value(int shift);
      if ($urandom_range(0, 9) == 0) return $urandom();
      return $signed($urandom_range(0, 32'h1FFFF) - 32'h10000) <<< shift;
   endfunction

   function automatic cull_item_t plane_load(int slot, int axis, bit flip, int half_width);
      cull_item_t it;
      it = '{kind: REQ_LOAD, slot: slot[2:0], default: 0};
      case (axis)
         0: it.ax = flip ? -32'sh10000 : 32'sh10000;
         1: it.ay = flip ? -32'sh10000 : 32'sh10000;
         default: it.az = flip ? -32'sh10000 : 32'sh10000;
      endcase
      it.scalar = half_width <<< FRAC_BITS;
      return it;
   endfunction

   function automatic cull_item_t random_item();
      cull_item_t it;
      int sh;
      sh = $urandom_range(0, 8);
      it.kind = $urandom_range(0, 9) == 0 ? REQ_LOAD : 2'($urandom_range(1, 3));
      it.slot = $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      it.ax = pick_value(sh); it.ay = pick_value(sh); it.az = pick_value(sh);
      it.bx = pick_value(sh); it.by = pick_value(sh); it.bz = pick_value(sh);
      if (it.kind == REQ_LOAD) begin
         // Unit-ish normals keep planes meaningful most of the time.
         if ($urandom_range(0, 3) != 0) begin
            it.ax = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
            it.ay = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
            it.az = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
         end
      end
      it.scalar = pick_value(sh);
      it.bias = $urandom_range(0, 3) == 0 ? pick_value(sh) : 0;
      it.early = $urandom_range(0, 1);
      return it;
   endfunction

   initial begin
      cull_item_t it;
      logic signed [31:0] ext[4];
      ext = '{32'sh7FFFFFFF, 32'sh80000000, 0, -1};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Tests against the all-zero planes right after reset.
      it = '{kind: REQ_SPHERE, scalar: 32'sh10000, default: 0};
      send_item(it, 0);
      it = '{kind: REQ_BOX, default: 0};
      send_item(it, 0);
      it = '{kind: REQ_LINE, ax: -1, bx: 1, default: 0};
      send_item(it, 0);
      // A cube frustum of half-width 10.
      for (int k = 0; k < NUM_PLANES; k++) send_item(plane_load(k, k / 2, k[0], 10), 0);
      // Loads to missing slots must not disturb the planes.
      it = '{kind: REQ_LOAD, slot: 6, ax: 32'sh7FFFFFFF, scalar: 32'sh80000000, default: 0};
      send_item(it, 0);
      it.slot = 7;
      send_item(it, 0);
      it = '{kind: REQ_SPHERE, scalar: 32'sh10000, default: 0};
      send_item(it, 0);                                   // inside
      it.ax = 32'sh000A0000;
      send_item(it, 0);                                   // intersect
      it.ax = 32'sh7FFFFFFF; it.scalar = 32'sh7FFFFFFF; it.bias = 32'sh7FFFFFFF;
      send_item(it, 0);
      it = '{kind: REQ_SPHERE, scalar: 32'sh80000000, bias: 32'sh80000000, default: 0};
      send_item(it, 0);                                   // negative radius sum
      it = '{kind: REQ_BOX, ax: -32'sh10000, ay: -32'sh10000, az: -32'sh10000,
             bx: 32'sh10000, by: 32'sh10000, bz: 32'sh10000, default: 0};
      send_item(it, 0);                                   // inside
      it.early = 1;
      send_item(it, 0);
      it = '{kind: REQ_BOX, ax: 32'sh00140000, ay: 0, az: 0,
             bx: -32'sh00140000, by: 32'sh10000, bz: 32'sh10000, default: 0};
      send_item(it, 0);                                   // inverted box
      it = '{kind: REQ_BOX, ax: 32'sh00140000, bx: 32'sh00200000, default: 0};
      send_item(it, 0);                                   // outside
      it = '{kind: REQ_LINE, ax: 32'sh80000000, bx: 32'sh7FFFFFFF, default: 0};
      send_item(it, 0);
      it = '{kind: REQ_LINE, ax: 32'sh00140000, bx: 32'sh00200000, default: 0};
      send_item(it, 0);
      for (int i = 0; i < 4; i++) begin
         it = '{kind: REQ_LOAD, slot: 3'(i), ax: ext[i], ay: ext[(i+1)%4],
                az: ext[(i+2)%4], scalar: ext[(i+3)%4], default: 0};
         send_item(it, 0);
      end
      it = '{kind: REQ_SPHERE, ax: ext[0], ay: ext[1], az: ext[0],
             scalar: ext[1], bias: ext[1], default: 0};
      send_item(it, 0);
      it = '{kind: REQ_BOX, ax: ext[1], ay: ext[1], az: ext[1],
             bx: ext[0], by: ext[0], bz: ext[0], early: 0, default: 0};
      send_item(it, 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            // Rebuild a sensible frustum of random size every so often.
            for (int k = 0; k < NUM_PLANES; k++)
               send_item(plane_load(k, k / 2, k[0], $urandom_range(1, 200)), 1);
         end
         if (n == 300) hold_receiver = 1;
         if (n == 600) drain();
         send_item(random_item(), (n % 100) > 30);
      end
      drain();
      repeat (60) @(posedge clock);
      $display("Covered %0d loads, %0d sphere, %0d box and %0d segment tests; %0d checked.",
               kind_count[0], kind_count[1], kind_count[2], kind_count[3], verdicts.checked);
      if (verdicts.mismatches == 0 && verdicts.pending_verdicts.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule

### files.f
hw/rtl/vfc_pkg.sv
hw/rtl/vfc_eval.sv
hw/rtl/view_frustum_culling.sv
test/view_frustum_culling_tb.sv
